// ===== src/cdq_pkg.sv =====
// Shared types and constants for the circular deque.
// Used by the channel interfaces, the controller, the datapath and the top level.
package cdq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int DATA_W     = 32;
   localparam int OP_W       = 3;
   localparam int STATUS_W   = 2;
   localparam int CAP_W      = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // register index, taken from paddr[2]
   localparam logic REG_CAPACITY = 1'b0;

   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
   localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_PUSH_FRONT,
      ACT_PUSH_REAR,
      ACT_POP_FRONT,
      ACT_POP_REAR,
      ACT_PEEK
   } action_type;

   typedef struct packed {
      logic                load;
      logic                rd_tail;
      logic                commit;
      action_type          action;
      logic [STATUS_W-1:0] status;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } stat_type;

endpackage

// ===== src/cdq_if.sv =====
// Valid/ready channel interfaces for the deque request and response transactions.
// Depends on cdq_pkg for field widths.
interface cdq_req_if;
   import cdq_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [OP_W-1:0]            operation;
   logic signed [DATA_W-1:0]   value;

   modport source (output valid, output operation, output value, input ready);
   modport sink   (input valid, input operation, input value, output ready);
endinterface

interface cdq_rsp_if;
   import cdq_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [STATUS_W-1:0]        status;
   logic signed [DATA_W-1:0]   data;
   logic                       is_empty;
   logic                       is_full;

   modport source (output valid, output status, output data, output is_empty,
                   output is_full, input ready);
   modport sink   (input valid, input status, input data, input is_empty,
                   input is_full, output ready);
endinterface

// ===== src/cdq_ctrl.sv =====
// Deque controller: request/response handshake, operation decode, commit timing.
// Depends on cdq_pkg; drives the datapath through cmd_type, reads stat_type.
module cdq_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic [cdq_pkg::OP_W-1:0]    req_op,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   input  cdq_pkg::stat_type           stat,
   output cdq_pkg::cmd_type            cmd
);
   import cdq_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic             state_ff, state_in;
   logic [OP_W-1:0]  op_ff, op_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accept;
   logic             out_free;
   logic             commit;
   action_type       action;
   logic [STATUS_W-1:0] status;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      action = ACT_NONE;
      status = ST_DONE;
      unique case (op_ff)
         OP_PUSH_FRONT, OP_PUSH_REAR: begin
            if (stat.full) begin
               status = ST_FULL;
            end else begin
               action = (op_ff == OP_PUSH_FRONT) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
            end
         end
         OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT: begin
            if (stat.empty) begin
               status = ST_EMPTY;
            end else if (op_ff == OP_POP_FRONT) begin
               action = ACT_POP_FRONT;
            end else if (op_ff == OP_POP_REAR) begin
               action = ACT_POP_REAR;
            end else begin
               action = ACT_PEEK;
            end
         end
         default: begin
            action = ACT_NONE;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      commit   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   assign cmd.load    = accept;
   assign cmd.rd_tail = (req_op == OP_POP_REAR);
   assign cmd.commit  = commit;
   assign cmd.action  = action;
   assign cmd.status  = status;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
   end

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      commit && (action == ACT_PUSH_FRONT || action == ACT_PUSH_REAR) |-> !stat.full)
      else $error("push committed into full deque");

   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      commit && (action == ACT_POP_FRONT || action == ACT_POP_REAR || action == ACT_PEEK)
      |-> !stat.empty)
      else $error("read committed on empty deque");

   a_exec_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC) && !out_free |=> (state_ff == ST_EXEC) && $stable(op_ff))
      else $error("transaction lost while response blocked");

endmodule

// ===== src/cdq_dp.sv =====
// Deque datapath: slot memory, head/tail indices, capacity register, response registers.
// Depends on cdq_pkg; commanded by cdq_ctrl through cmd_type.
module cdq_dp #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  cdq_pkg::cmd_type                   cmd,
   output cdq_pkg::stat_type                  stat,
   input  logic signed [cdq_pkg::DATA_W-1:0]  req_value,
   input  logic                               cfg_we,
   input  logic [cdq_pkg::CAP_W-1:0]          cfg_wdata,
   output logic [cdq_pkg::CAP_W-1:0]          capacity,
   output logic [cdq_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [cdq_pkg::DATA_W-1:0]  rsp_data,
   output logic                               rsp_is_empty,
   output logic                               rsp_is_full
);
   import cdq_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = (IDX_W + 1 > CAP_W) ? IDX_W + 1 : CAP_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   logic signed [DATA_W-1:0] mem [DEPTH];

   logic [CAP_W-1:0]         capacity_ff, capacity_in;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [IDX_W-1:0]         tail_ff, tail_in;
   logic                     empty_ff, empty_in;
   logic signed [DATA_W-1:0] rd_data_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic [STATUS_W-1:0]      status_ff;
   logic signed [DATA_W-1:0] data_ff, data_in;
   logic                     is_empty_ff;
   logic                     is_full_ff, is_full_in;

   logic [CW-1:0]            cap_x;
   logic [CW-1:0]            eff_cap;
   logic [IDX_W-1:0]         rd_addr;
   logic [IDX_W-1:0]         wr_addr;
   logic                     wr_en;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
                                                 input logic [CW-1:0] c);
      logic [CW-1:0] inc;
      inc = CW'(i) + ONE_C;
      if (inc >= c) return '0;
      return IDX_W'(inc);
   endfunction

   function automatic logic [IDX_W-1:0] prev_idx(input logic [IDX_W-1:0] i,
                                                 input logic [CW-1:0] c);
      logic [CW-1:0] ix;
      ix = CW'(i);
      if (ix == '0 || ix >= c) return IDX_W'(c - ONE_C);
      return IDX_W'(ix - ONE_C);
   endfunction

   always_comb begin
      cap_x = CW'(capacity_ff);
      if (cap_x == '0) begin
         eff_cap = ONE_C;
      end else if (cap_x > DEPTH_C) begin
         eff_cap = DEPTH_C;
      end else begin
         eff_cap = cap_x;
      end
   end

   assign stat.empty = empty_ff;
   assign stat.full  = !empty_ff && (next_idx(tail_ff, eff_cap) == head_ff);

   assign rd_addr = cmd.rd_tail ? tail_ff : head_ff;

   always_comb begin
      capacity_in = capacity_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      empty_in    = empty_ff;
      wr_en       = 1'b0;
      wr_addr     = head_ff;
      data_in     = '0;
      priority if (cfg_we) begin
         capacity_in = cfg_wdata;
         head_in     = '0;
         tail_in     = '0;
         empty_in    = 1'b1;
      end else if (cmd.commit) begin
         unique case (cmd.action)
            ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
               wr_en = 1'b1;
               if (empty_ff) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b0;
                  wr_addr  = '0;
               end else if (cmd.action == ACT_PUSH_FRONT) begin
                  head_in = prev_idx(head_ff, eff_cap);
                  wr_addr = head_in;
               end else begin
                  tail_in = next_idx(tail_ff, eff_cap);
                  wr_addr = tail_in;
               end
            end
            ACT_POP_FRONT, ACT_POP_REAR: begin
               data_in = rd_data_ff;
               if (head_ff == tail_ff) begin
                  head_in  = '0;
                  tail_in  = '0;
                  empty_in = 1'b1;
               end else if (cmd.action == ACT_POP_FRONT) begin
                  head_in = next_idx(head_ff, eff_cap);
               end else begin
                  tail_in = prev_idx(tail_ff, eff_cap);
               end
            end
            ACT_PEEK: begin
               data_in = rd_data_ff;
            end
            default: begin
               data_in = '0;
            end
         endcase
      end
   end

   assign is_full_in = !empty_in && (next_idx(tail_in, eff_cap) == head_in);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= value_ff;
      end
      if (cmd.load) begin
         rd_data_ff <= mem[rd_addr];
         value_ff   <= req_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAP_RESET;
         head_ff     <= '0;
         tail_ff     <= '0;
         empty_ff    <= 1'b1;
      end else begin
         capacity_ff <= capacity_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         empty_ff    <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff   <= cmd.status;
         data_ff     <= data_in;
         is_empty_ff <= empty_in;
         is_full_ff  <= is_full_in;
      end
   end

   assign capacity     = capacity_ff;
   assign rsp_status   = status_ff;
   assign rsp_data     = data_ff;
   assign rsp_is_empty = is_empty_ff;
   assign rsp_is_full  = is_full_ff;

   a_empty_at_origin: assert property (@(posedge clock) disable iff (reset)
      empty_ff |-> (head_ff == '0) && (tail_ff == '0))
      else $error("empty deque with nonzero index");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      (CW'(head_ff) < eff_cap) && (CW'(tail_ff) < eff_cap))
      else $error("index beyond capacity");

   a_last_pop_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && !cfg_we && (cmd.action == ACT_POP_FRONT || cmd.action == ACT_POP_REAR)
      && (head_ff == tail_ff) |=> empty_ff)
      else $error("last pop did not empty deque");

endmodule

// ===== src/circular_deque.sv =====
// Circular deque top level: accepting a request moves the controller to its execute state, whose
// commit sets the registered response valid; the response transaction follows that.
// A new request is taken only once the previous one commits: a registered slot-memory read, then a commit
// that updates indices and loads the response register; a stalled response holds commit.
// Reset is synchronous: head and tail to 0, deque empty, capacity 16; slots are not cleared.
// Depends on cdq_pkg, cdq_if, cdq_ctrl and cdq_dp.
module circular_deque #(
   parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   cdq_req_if.sink                             req_ch,
   cdq_rsp_if.source                           rsp_ch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cdq_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [cdq_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [cdq_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);
   import cdq_pkg::*;

   cmd_type           cmd;
   stat_type          stat;
   logic              cfg_we;
   logic              reg_hit;
   logic [CAP_W-1:0]  capacity;
   logic              req_ready;
   logic              rsp_valid;

   assign csr_pready = 1'b1;
   assign reg_hit    = (csr_paddr[CSR_ADDR_W-1] == REG_CAPACITY);
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && csr_pready && reg_hit;
   assign csr_prdata = reg_hit ? CSR_DATA_W'(capacity) : '0;

   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_op    (req_ch.operation),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   cdq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_value    (req_ch.value),
      .cfg_we       (cfg_we),
      .cfg_wdata    (csr_pwdata[CAP_W-1:0]),
      .capacity     (capacity),
      .rsp_status   (rsp_ch.status),
      .rsp_data     (rsp_ch.data),
      .rsp_is_empty (rsp_ch.is_empty),
      .rsp_is_full  (rsp_ch.is_full)
   );

   assign req_ch.ready = req_ready;
   assign rsp_ch.valid = rsp_valid;

endmodule

// ===== test/circular_deque_tb.sv =====
// Self-checking testbench for circular_deque: directed and random push/pop/peek traffic
// with random idling, a long response hold-off and capacity changes over the CSR port.
// Depends on cdq_pkg, cdq_if and the circular_deque RTL.
module circular_deque_tb;
   import cdq_pkg::*;

   localparam int SLOT_COUNT = DEPTH_DEFAULT;
   localparam logic [CSR_ADDR_W-1:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_SPARE    = {~REG_CAPACITY, 2'b00};
   localparam logic [OP_W-1:0]       OP_LAST_CODE  = '1;
   localparam int PHASE_ITEMS = 78;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [DATA_W-1:0]   data;
      logic                is_empty;
      logic                is_full;
   } deque_result_type;

   class deque_scoreboard_type;
      logic [DATA_W-1:0] slots [SLOT_COUNT];
      int unsigned       head;
      int unsigned       tail;
      bit                empty;
      logic [CAP_W-1:0]  cap_reg;
      deque_result_type  awaited[$];
      int                errors;

      function new();
         foreach (slots[i]) slots[i] = '0;
         cap_reg = CAP_RESET;
         errors  = 0;
         clear();
      endfunction

      function void clear();
         head  = 0;
         tail  = 0;
         empty = 1'b1;
      endfunction

      function int unsigned slots_used();
         if (cap_reg == 0) return 1;
         if (cap_reg > SLOT_COUNT) return SLOT_COUNT;
         return cap_reg;
      endfunction

      function int unsigned next_slot(int unsigned i);
         return (i + 1 >= slots_used()) ? 0 : i + 1;
      endfunction

      function int unsigned prev_slot(int unsigned i);
         if (i == 0 || i >= slots_used()) return slots_used() - 1;
         return i - 1;
      endfunction

      function bit full_now();
         return !empty && next_slot(tail) == head;
      endfunction

      function int pending();
         return awaited.size();
      endfunction

      // a write to any index but capacity is a no-op
      function void write_reg(logic index, logic [CSR_DATA_W-1:0] wdata);
         if (index == REG_CAPACITY) begin
            cap_reg = wdata[CAP_W-1:0];
            clear();
         end
      endfunction

      function void apply_op(logic [OP_W-1:0] op, logic [DATA_W-1:0] val);
         deque_result_type r;
         r.status = ST_DONE;
         r.data   = '0;
         if (op == OP_PUSH_FRONT || op == OP_PUSH_REAR) begin
            if (full_now()) begin
               r.status = ST_FULL;
            end else if (empty) begin
               head     = 0;
               tail     = 0;
               empty    = 1'b0;
               slots[0] = val;
            end else if (op == OP_PUSH_FRONT) begin
               head        = prev_slot(head);
               slots[head] = val;
            end else begin
               tail        = next_slot(tail);
               slots[tail] = val;
            end
         end else if (op == OP_POP_FRONT || op == OP_POP_REAR || op == OP_PEEK_FRONT) begin
            if (empty) begin
               r.status = ST_EMPTY;
            end else if (op == OP_PEEK_FRONT) begin
               r.data = slots[head];
            end else begin
               r.data = (op == OP_POP_FRONT) ? slots[head] : slots[tail];
               if (head == tail) clear();
               else if (op == OP_POP_FRONT) head = next_slot(head);
               else tail = prev_slot(tail);
            end
         end
         r.is_empty = empty;
         r.is_full  = full_now();
         awaited.push_back(r);
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH @%0t: %s", $time, msg);
      endtask

      task check_response(logic [STATUS_W-1:0] st, logic [DATA_W-1:0] d, logic e, logic f);
         deque_result_type want;
         if (awaited.size() == 0) begin
            report("response transaction with nothing pending");
            return;
         end
         want = awaited.pop_front();
         if (st !== want.status)
            report($sformatf("status got %0d want %0d", st, want.status));
         if (d !== want.data)
            report($sformatf("data got %08h want %08h", d, want.data));
         if (e !== want.is_empty)
            report($sformatf("is_empty got %b want %b", e, want.is_empty));
         if (f !== want.is_full)
            report($sformatf("is_full got %b want %b", f, want.is_full));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   cdq_req_if req_ch ();
   cdq_rsp_if rsp_ch ();

   circular_deque i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   deque_scoreboard_type sb = new();

   int req_idle_pct;
   bit rsp_idle_on;
   bit hold_request;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   // response side: random stall bursts plus one long hold-off on request
   initial begin
      int long_hold;
      int gap;
      long_hold = 0;
      gap       = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            long_hold    = 60;
         end
         if (long_hold > 0) begin
            rsp_ch.ready <= 1'b0;
            long_hold--;
         end else if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            gap--;
         end else if (rsp_idle_on && $urandom_range(0, 9) == 0) begin
            rsp_ch.ready <= 1'b0;
            gap = $urandom_range(1, 14) - 1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_response(rsp_ch.status, rsp_ch.data, rsp_ch.is_empty, rsp_ch.is_full);
   end

   task send_item(logic [OP_W-1:0] op, logic [DATA_W-1:0] val);
      int n;
      if (req_idle_pct != 0 && $urandom_range(0, 99) < req_idle_pct) begin
         n = $urandom_range(1, 14);
         @(negedge clock);
         req_ch.valid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.value     <= val;
      do @(posedge clock); while (!req_ch.ready);
      sb.apply_op(op, val);
   endtask

   task stop_stream();
      @(negedge clock);
      req_ch.valid <= 1'b0;
   endtask

   // let every response drain, then wait out the commit stage
   task wait_idle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] wdata);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(addr[2], wdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task run_random(int count);
      int push_pct;
      int roll;
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] val;
      push_pct = 50;
      for (int k = 0; k < count; k++) begin
         if (k % 16 == 0) push_pct = $urandom_range(15, 85);
         roll = $urandom_range(0, 99);
         if (roll < 4)
            op = OP_W'($urandom_range(OP_PEEK_FRONT + 1, OP_LAST_CODE));
         else if (roll < push_pct)
            op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
         else begin
            case ($urandom_range(0, 4))
               0, 1: op = OP_POP_FRONT;
               2, 3: op = OP_POP_REAR;
               default: op = OP_PEEK_FRONT;
            endcase
         end
         case ($urandom_range(0, 11))
            0: val = 32'h7FFF_FFFF;
            1: val = 32'h8000_0000;
            2: val = '0;
            3: val = '1;
            default: val = $urandom;
         endcase
         send_item(op, val);
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] caps [12];
      clock            = 1'b0;
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.operation = '0;
      req_ch.value     = '0;
      rsp_ch.ready     = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      req_idle_pct     = 0;
      rsp_idle_on      = 1'b1;
      hold_request     = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty refusals, first push, both ends, unknown codes, last pop
      req_idle_pct = 20;
      send_item(OP_POP_FRONT, $urandom);
      send_item(OP_POP_REAR, $urandom);
      send_item(OP_PEEK_FRONT, $urandom);
      send_item(OP_PUSH_FRONT, 32'h7FFF_FFFF);
      send_item(OP_PEEK_FRONT, $urandom);
      send_item(OP_PUSH_REAR, 32'h8000_0000);
      send_item(OP_PUSH_FRONT, 32'hFFFF_FFFF);
      send_item(OP_PUSH_REAR, 32'h0000_0000);
      send_item(OP_W'(OP_PEEK_FRONT + 1), $urandom);
      send_item(OP_W'(OP_PEEK_FRONT + 2), $urandom);
      send_item(OP_LAST_CODE, $urandom);
      send_item(OP_POP_REAR, $urandom);
      send_item(OP_POP_FRONT, $urandom);
      send_item(OP_POP_FRONT, $urandom);
      send_item(OP_POP_REAR, $urandom);
      send_item(OP_PEEK_FRONT, $urandom);
      stop_stream();
      wait_idle();

      // capacity zero acts as one slot: full refusals from both ends
      csr_write(ADDR_CAPACITY, 32'd0);
      send_item(OP_PUSH_REAR, 32'h1234_5678);
      send_item(OP_PUSH_FRONT, $urandom);
      send_item(OP_PUSH_REAR, $urandom);
      send_item(OP_PEEK_FRONT, $urandom);
      send_item(OP_POP_FRONT, $urandom);
      stop_stream();
      wait_idle();

      caps = '{32'd1, 32'd2, 32'd3, 32'd16, 32'd31, 32'd17, 32'd8, 32'hFFFF_FFE3,
               $urandom_range(1, 16), $urandom_range(1, 16), 32'd5, 32'd16};
      for (int i = 0; i < 12; i++) begin
         csr_write(ADDR_CAPACITY, caps[i]);
         if (i == 11) begin
            req_idle_pct = 0;
            rsp_idle_on  = 1'b0;
         end else if (i % 3 == 2) begin
            req_idle_pct = 0;
            rsp_idle_on  = 1'b0;
         end else begin
            req_idle_pct = $urandom_range(0, 1) ? 10 : 30;
            rsp_idle_on  = 1'b1;
         end
         if (i == 3) begin
            req_idle_pct = 0;
            hold_request = 1'b1;
         end
         if (i == 6) begin
            run_random(PHASE_ITEMS / 2);
            stop_stream();
            wait_idle();
            csr_write(ADDR_SPARE, $urandom);
            run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
         end else begin
            run_random(PHASE_ITEMS);
         end
         stop_stream();
         wait_idle();
      end

      begin
         int drain;
         drain = 0;
         while (sb.pending() != 0 && drain < 10000) begin
            @(posedge clock);
            drain++;
         end
         if (sb.pending() != 0) sb.report("responses still outstanding at end of run");
      end
      repeat (10) @(posedge clock);
      if (sb.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
